@@ sv/dptcp_pkg.sv @@
// Shared types, constants and the jet color function for the depth-to-point pipeline.
`default_nettype none
package dptcp_pkg;

	localparam int CodeW   = 8;
	localparam int PixW    = 8;
	localparam int RecipW  = 25;
	localparam int CenterW = 26;
	localparam int ScaleW  = 25;
	localparam int CfgW    = 26;
	localparam int CfgIdxW = 3;
	localparam int ZW      = 32;
	localparam int CoordW  = 41;
	localparam int ColorW  = 24;
	localparam int InTdataW  = 24;
	localparam int OutTdataW = 144;

	localparam logic [RecipW-1:0]  RecipMax   = 25'd16777216;
	localparam logic [CenterW-1:0] CenterMax  = 26'd66846720;
	localparam logic [ScaleW-1:0]  ScaleMax   = 25'd16777216;
	localparam logic [RecipW-1:0]  RecipRst   = 25'd209715;
	localparam logic [CenterW-1:0] CenterCRst = 26'd10485760;
	localparam logic [CenterW-1:0] CenterRRst = 26'd7864320;
	localparam logic [ScaleW-1:0]  ScaleRst   = 25'd164483;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RECIP_X  = 3'd0,
		CFG_RECIP_Y  = 3'd1,
		CFG_CENTER_C = 3'd2,
		CFG_CENTER_R = 3'd3,
		CFG_SCALE    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [RecipW-1:0]  recip_x;
		logic [RecipW-1:0]  recip_y;
		logic [CenterW-1:0] center_col;
		logic [CenterW-1:0] center_row;
		logic [ScaleW-1:0]  scale;
	} cfg_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

	function automatic logic [ColorW-1:0] jet_color(input logic [CodeW-1:0] i);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] t;
		r = 8'd0;
		g = 8'd0;
		b = 8'd0;
		t = 8'd0;
		if (i < 8'd32) begin
			r = 8'd128 + {i[5:0], 2'b00};
		end else if (i == 8'd32) begin
			r = 8'd255;
		end else if (i < 8'd96) begin
			t = i - 8'd32;
			r = 8'd255;
			g = {t[5:0], 2'b00};
		end else if (i == 8'd96) begin
			r = 8'd254;
			g = 8'd255;
			b = 8'd1;
		end else if (i < 8'd160) begin
			t = i - 8'd97;
			r = 8'd250 - {t[5:0], 2'b00};
			g = 8'd255;
			b = 8'd6 + {t[5:0], 2'b00};
		end else if (i < 8'd224) begin
			t = i - 8'd160;
			g = 8'd252 - {t[5:0], 2'b00};
			b = 8'd255;
		end else begin
			t = i - 8'd224;
			b = 8'd252 - {t[5:0], 2'b00};
		end
		return {r, g, b};
	endfunction

endpackage
`default_nettype wire

@@ sv/dptcp_cfg.sv @@
// Calibration registers with write-side saturation.
`default_nettype none
module dptcp_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [dptcp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [dptcp_pkg::CfgW-1:0]    cfg_data,
	output dptcp_pkg::cfg_t                    cfg
);

	logic [dptcp_pkg::RecipW-1:0]  recip_sat;
	logic [dptcp_pkg::CenterW-1:0] center_sat;
	logic [dptcp_pkg::ScaleW-1:0]  scale_sat;
	dptcp_pkg::cfg_t               cfg_q;

	always_comb begin
		recip_sat  = (cfg_data[dptcp_pkg::RecipW-1:0] > dptcp_pkg::RecipMax) ?
			dptcp_pkg::RecipMax : cfg_data[dptcp_pkg::RecipW-1:0];
		center_sat = (cfg_data > dptcp_pkg::CenterMax) ? dptcp_pkg::CenterMax : cfg_data;
		scale_sat  = (cfg_data[dptcp_pkg::ScaleW-1:0] > dptcp_pkg::ScaleMax) ?
			dptcp_pkg::ScaleMax : cfg_data[dptcp_pkg::ScaleW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recip_x    <= dptcp_pkg::RecipRst;
			cfg_q.recip_y    <= dptcp_pkg::RecipRst;
			cfg_q.center_col <= dptcp_pkg::CenterCRst;
			cfg_q.center_row <= dptcp_pkg::CenterRRst;
			cfg_q.scale      <= dptcp_pkg::ScaleRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dptcp_pkg::CFG_RECIP_X:  cfg_q.recip_x    <= recip_sat;
				dptcp_pkg::CFG_RECIP_Y:  cfg_q.recip_y    <= recip_sat;
				dptcp_pkg::CFG_CENTER_C: cfg_q.center_col <= center_sat;
				dptcp_pkg::CFG_CENTER_R: cfg_q.center_row <= center_sat;
				dptcp_pkg::CFG_SCALE:    cfg_q.scale      <= scale_sat;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ sv/dptcp_coord.sv @@
// One lateral axis: offset, reciprocal multiply, split multiply by range, final sum.
`default_nettype none
module dptcp_coord (
	input  wire logic                                clk,
	input  wire dptcp_pkg::pipe_en_t                 en,
	input  wire logic [dptcp_pkg::PixW-1:0]          pix,
	input  wire logic [dptcp_pkg::CenterW-1:0]       center,
	input  wire logic [dptcp_pkg::RecipW-1:0]        recip,
	input  wire logic [dptcp_pkg::ZW-1:0]            z_s2,
	output logic signed [dptcp_pkg::CoordW-1:0]      coord_s4
);

	localparam int DiffW = dptcp_pkg::CenterW + 1;
	localparam int ProdW = DiffW + dptcp_pkg::RecipW + 1;
	localparam int CW    = ProdW - 18;
	localparam int HiW   = CW - 24;
	localparam int ZhiW  = dptcp_pkg::ZW + 1 + HiW;
	localparam int ZloW  = dptcp_pkg::ZW + 24;

	logic signed [DiffW-1:0] diff_in;
	logic signed [DiffW-1:0] diff_s1;
	logic signed [ProdW-1:0] prod_s2;
	logic signed [CW-1:0]    c_val;
	logic signed [HiW-1:0]   c_hi;
	logic        [23:0]      c_lo;
	logic signed [ZhiW-1:0]  zhi_s3;
	logic        [ZloW-1:0]  zlo_s3;
	logic signed [ZhiW-1:0]  sum;

	always_comb begin
		diff_in = $signed({1'b0, pix, 18'b0}) - $signed({1'b0, center});
		// floor shift by 18, then split into signed integer and 24-bit fraction
		c_val = prod_s2[ProdW-1:18];
		c_hi  = c_val[CW-1:24];
		c_lo  = c_val[23:0];
		sum   = zhi_s3 + $signed({{(ZhiW-dptcp_pkg::ZW){1'b0}}, zlo_s3[ZloW-1:24]});
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) diff_s1 <= diff_in;
		if (en.en_s2) prod_s2 <= diff_s1 * $signed({1'b0, recip});
		if (en.en_s3) begin
			zhi_s3 <= $signed({1'b0, z_s2}) * c_hi;
			zlo_s3 <= z_s2 * c_lo;
		end
		if (en.en_s4) coord_s4 <= sum[dptcp_pkg::CoordW-1:0];
	end

endmodule
`default_nettype wire

@@ sv/depth_pixel_to_colored_point.sv @@
// Top level: depth pixel to colored 3-D point, four-stage pipeline.
//
//  port group  | dir | contents
//  s_axis_*    | in  | tdata: depth_code[7:0], pixel_col[15:8], pixel_row[23:16]
//  m_axis_*    | out | tdata: point_x, point_y, point_z, color_rgb, zero pad
//  cfg_*       | in  | register write: index, data; no read-back
//
// Output valid rises once the transaction has passed the stage 1 to 4 registers; one pixel per cycle
// while m_axis_tready does not stall the output. Stage 1 forms range, pixel offsets and color; stage 2
// the reciprocal products; stage 3 the range products; stage 4 the sums, which form the output register.
// Each stage takes new data when empty or when the next stage moves, so bubbles close up.
// arst_n clears the stage valid bits and loads the default calibration.
`default_nettype none
module depth_pixel_to_colored_point (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// depth_code, pixel_col, pixel_row
	input  wire logic [dptcp_pkg::InTdataW-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// point_x, point_y, point_z, color_rgb, zero pad
	output logic [dptcp_pkg::OutTdataW-1:0]        m_axis_tdata,
	input  wire logic                              cfg_wr_en,
	input  wire logic [dptcp_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [dptcp_pkg::CfgW-1:0]        cfg_data
);

	localparam int PadW = dptcp_pkg::OutTdataW - 2 * dptcp_pkg::CoordW - dptcp_pkg::ZW
		- dptcp_pkg::ColorW;

	dptcp_pkg::cfg_t     cfg;
	dptcp_pkg::pipe_en_t en;

	logic [dptcp_pkg::CodeW-1:0] depth_code;
	logic [dptcp_pkg::PixW-1:0]  pixel_col;
	logic [dptcp_pkg::PixW-1:0]  pixel_row;
	logic [dptcp_pkg::ZW-1:0]    z_full;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [dptcp_pkg::ZW-1:0]     z_s1, z_s2, z_s3, z_s4;
	logic [dptcp_pkg::ColorW-1:0] color_s1, color_s2, color_s3, color_s4;
	logic signed [dptcp_pkg::CoordW-1:0] x_s4, y_s4;

	assign depth_code = s_axis_tdata[7:0];
	assign pixel_col  = s_axis_tdata[15:8];
	assign pixel_row  = s_axis_tdata[23:16];
	assign z_full     = {{(dptcp_pkg::ZW - dptcp_pkg::CodeW){1'b0}}, depth_code}
		* {{(dptcp_pkg::ZW - dptcp_pkg::ScaleW){1'b0}}, cfg.scale};

	always_comb begin
		en.en_s4 = !v_s4 || m_axis_tready;
		en.en_s3 = !v_s3 || en.en_s4;
		en.en_s2 = !v_s2 || en.en_s3;
		en.en_s1 = !v_s1 || en.en_s2;
	end

	assign s_axis_tready = en.en_s1;

	dptcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dptcp_coord u_coord_x (
		.clk      (clk),
		.en       (en),
		.pix      (pixel_col),
		.center   (cfg.center_col),
		.recip    (cfg.recip_x),
		.z_s2     (z_s2),
		.coord_s4 (x_s4)
	);

	dptcp_coord u_coord_y (
		.clk      (clk),
		.en       (en),
		.pix      (pixel_row),
		.center   (cfg.center_row),
		.recip    (cfg.recip_y),
		.z_s2     (z_s2),
		.coord_s4 (y_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= s_axis_tvalid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en.en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			z_s1     <= z_full;
			color_s1 <= dptcp_pkg::jet_color(depth_code);
		end
		if (en.en_s2) begin
			z_s2     <= z_s1;
			color_s2 <= color_s1;
		end
		if (en.en_s3) begin
			z_s3     <= z_s2;
			color_s3 <= color_s2;
		end
		if (en.en_s4) begin
			z_s4     <= z_s3;
			color_s4 <= color_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {{PadW{1'b0}}, color_s4, z_s4, y_s4, x_s4};

endmodule
`default_nettype wire

@@ sv/dptcp_checker.sv @@
// Port-level checks for the depth-to-point pipeline, bound to the top level.
`default_nettype none
module dptcp_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [dptcp_pkg::OutTdataW-1:0]    m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled output data changed");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without an output stall");

	a_color_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[137:114] != 24'd0)
		else $error("jet color is black");

endmodule

bind depth_pixel_to_colored_point dptcp_checker u_dptcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
